>>> design/dstwr_pkg.sv
// shared constants and types for the two-way ranging time-of-flight block
`default_nettype none

package dstwr_pkg;

   localparam int DEF_STAMP_BITS = 32;
   localparam int FLIGHT_BITS    = 34;

   // side information that rides along the divider stages
   typedef struct packed {
      logic neg;
      logic zero;
   } dstwr_tag_type;

endpackage

`default_nettype wire

>>> design/dstwr_divider.sv
// pipelined restoring divider, one quotient bit per register stage
`default_nettype none

module dstwr_divider
   import dstwr_pkg::*;
#(
   parameter int NUM_BITS = 2 * DEF_STAMP_BITS,
   parameter int DEN_BITS = DEF_STAMP_BITS + 2
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                advance,
   input  wire logic                in_valid,
   input  wire logic [NUM_BITS-1:0] in_num,
   input  wire logic [DEN_BITS-1:0] in_den,
   input  wire dstwr_tag_type       in_tag,
   output logic                     out_valid,
   output logic [NUM_BITS-1:0]      out_quo,
   output dstwr_tag_type            out_tag
);

   logic                valid_ff [NUM_BITS];
   logic [DEN_BITS-1:0] rem_ff   [NUM_BITS];
   logic [NUM_BITS-1:0] numq_ff  [NUM_BITS];
   logic [DEN_BITS-1:0] den_ff   [NUM_BITS];
   dstwr_tag_type       tag_ff   [NUM_BITS];

   logic [DEN_BITS-1:0] rem_in   [NUM_BITS];
   logic [NUM_BITS-1:0] numq_in  [NUM_BITS];

   // numerator bits leave at the top of numq while quotient bits enter at the bottom
   always_comb begin
      logic [DEN_BITS:0]   trial;
      logic [DEN_BITS-1:0] rem_src;
      logic [NUM_BITS-1:0] numq_src;
      logic [DEN_BITS-1:0] den_src;
      for (int s = 0; s < NUM_BITS; s++) begin
         if (s == 0) begin
            rem_src  = '0;
            numq_src = in_num;
            den_src  = in_den;
         end else begin
            rem_src  = rem_ff[s-1];
            numq_src = numq_ff[s-1];
            den_src  = den_ff[s-1];
         end
         trial = {rem_src, numq_src[NUM_BITS-1]};
         if (trial >= {1'b0, den_src}) begin
            rem_in[s]  = DEN_BITS'(trial - {1'b0, den_src});
            numq_in[s] = {numq_src[NUM_BITS-2:0], 1'b1};
         end else begin
            rem_in[s]  = trial[DEN_BITS-1:0];
            numq_in[s] = {numq_src[NUM_BITS-2:0], 1'b0};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int s = 0; s < NUM_BITS; s++) begin
            valid_ff[s] <= 1'b0;
         end
      end else if (advance) begin
         for (int s = 0; s < NUM_BITS; s++) begin
            if (s == 0) begin
               valid_ff[s] <= in_valid;
               den_ff[s]   <= in_den;
               tag_ff[s]   <= in_tag;
            end else begin
               valid_ff[s] <= valid_ff[s-1];
               den_ff[s]   <= den_ff[s-1];
               tag_ff[s]   <= tag_ff[s-1];
            end
            rem_ff[s]  <= rem_in[s];
            numq_ff[s] <= numq_in[s];
         end
      end
   end

   assign out_valid = valid_ff[NUM_BITS-1];
   assign out_quo   = numq_ff[NUM_BITS-1];
   assign out_tag   = tag_ff[NUM_BITS-1];

endmodule

`default_nettype wire

>>> design/ds_twr_time_of_flight.sv
// time of flight for one asymmetric double-sided two-way ranging exchange
//
// usage
//  - req channel: one transfer carries the six timestamps of an exchange
//    (initiator poll send, response receive, final send; responder poll
//    receive, response send, final receive), each STAMP_BITS wide
//  - rsp channel: one transfer per request, in order, with flight_time
//    = (Ra*Rb - Da*Db) / (Ra+Rb+Da+Db) truncated toward zero and
//    saturated to 34 bits signed; zero_divisor flags an all-zero sum
//  - every stage is registered: the intervals, partial products, full
//    products, numerator sign and magnitude, the one-bit-per-stage divider
//    pipeline, saturation and output lie between req and rsp_valid
//  - throughput: one transfer per cycle unless the skid register is full
//  - reset clears every valid bit; the pipeline empties, no result is kept
//  - receiver stall: a result waiting on rsp_ready is held in the output
//    register and a second one lands in a skid register; the pipeline and
//    req_ready stop only once the skid register is occupied, so nothing
//    is lost or repeated
`default_nettype none

module ds_twr_time_of_flight
   import dstwr_pkg::*;
#(
   parameter int STAMP_BITS = DEF_STAMP_BITS
) (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    req_valid,
   output logic                         req_ready,
   input  wire logic [STAMP_BITS-1:0]   req_remote_poll_sent,
   input  wire logic [STAMP_BITS-1:0]   req_remote_reply_seen,
   input  wire logic [STAMP_BITS-1:0]   req_remote_final_sent,
   input  wire logic [STAMP_BITS-1:0]   req_local_poll_seen,
   input  wire logic [STAMP_BITS-1:0]   req_local_reply_sent,
   input  wire logic [STAMP_BITS-1:0]   req_local_final_seen,
   output logic                         rsp_valid,
   input  wire logic                    rsp_ready,
   output logic signed [FLIGHT_BITS-1:0] rsp_flight_time,
   output logic                         rsp_zero_divisor
);

   localparam int W        = STAMP_BITS;
   localparam int H        = (W + 1) / 2;        // low half of the split multiplier operand
   localparam int PW       = 2 * W;              // product and quotient width
   localparam int SW       = W + 2;              // sum of four intervals
   localparam int EXT      = (PW > FLIGHT_BITS + 1) ? PW : FLIGHT_BITS + 1;
   localparam logic [EXT-1:0] POS_LIMIT =
      {{(EXT-FLIGHT_BITS+1){1'b0}}, {(FLIGHT_BITS-1){1'b1}}};
   localparam logic [EXT-1:0] NEG_LIMIT =
      {{(EXT-FLIGHT_BITS){1'b0}}, 1'b1, {(FLIGHT_BITS-1){1'b0}}};

   // whole pipeline moves together; it halts only when the skid register is full
   logic advance;
   logic skid_valid_ff;

   assign advance   = ~skid_valid_ff;
   assign req_ready = advance;

   // stage 1: the four intervals, wrapping subtraction
   logic         s1_valid_ff;
   logic [W-1:0] ra_ff, rb_ff, da_ff, db_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (advance) begin
         s1_valid_ff <= req_valid;
         ra_ff       <= req_remote_reply_seen - req_remote_poll_sent;
         rb_ff       <= req_local_final_seen - req_local_reply_sent;
         da_ff       <= req_remote_final_sent - req_remote_reply_seen;
         db_ff       <= req_local_reply_sent - req_local_poll_seen;
      end
   end

   // stage 2: partial products on split operands, interval sum
   logic             s2_valid_ff;
   logic [W+H-1:0]   prod_p_lo_ff, prod_q_lo_ff;
   logic [2*W-H-1:0] prod_p_hi_ff, prod_q_hi_ff;
   logic [SW-1:0]    sum2_ff;
   logic [SW-1:0]    sum2_in;

   assign sum2_in = SW'(ra_ff) + SW'(rb_ff) + SW'(da_ff) + SW'(db_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else if (advance) begin
         s2_valid_ff  <= s1_valid_ff;
         prod_p_lo_ff <= {{H{1'b0}}, ra_ff} * {{W{1'b0}}, rb_ff[H-1:0]};
         prod_p_hi_ff <= {{(W-H){1'b0}}, ra_ff} * {{W{1'b0}}, rb_ff[W-1:H]};
         prod_q_lo_ff <= {{H{1'b0}}, da_ff} * {{W{1'b0}}, db_ff[H-1:0]};
         prod_q_hi_ff <= {{(W-H){1'b0}}, da_ff} * {{W{1'b0}}, db_ff[W-1:H]};
         sum2_ff      <= sum2_in;
      end
   end

   // stage 3: full products Ra*Rb and Da*Db
   logic          s3_valid_ff;
   logic [PW-1:0] p_ff, q_ff;
   logic [SW-1:0] sum3_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s3_valid_ff <= 1'b0;
      end else if (advance) begin
         s3_valid_ff <= s2_valid_ff;
         p_ff        <= {prod_p_hi_ff, {H{1'b0}}} + PW'(prod_p_lo_ff);
         q_ff        <= {prod_q_hi_ff, {H{1'b0}}} + PW'(prod_q_lo_ff);
         sum3_ff     <= sum2_ff;
      end
   end

   // stage 4: sign and magnitude of the numerator, both differences side by side
   logic          s4_valid_ff;
   logic [PW-1:0] mag_ff;
   logic [SW-1:0] den_ff;
   dstwr_tag_type tag4_ff;
   logic [PW:0]   diff_pq_in, diff_qp_in;

   assign diff_pq_in = {1'b0, p_ff} - {1'b0, q_ff};
   assign diff_qp_in = {1'b0, q_ff} - {1'b0, p_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         s4_valid_ff <= 1'b0;
      end else if (advance) begin
         s4_valid_ff  <= s3_valid_ff;
         tag4_ff.neg  <= diff_pq_in[PW];
         tag4_ff.zero <= (sum3_ff == '0);
         mag_ff       <= diff_pq_in[PW] ? diff_qp_in[PW-1:0] : diff_pq_in[PW-1:0];
         den_ff       <= sum3_ff;
      end
   end

   // divider stages
   logic          div_valid;
   logic [PW-1:0] div_quo;
   dstwr_tag_type div_tag;

   dstwr_divider #(
      .NUM_BITS (PW),
      .DEN_BITS (SW)
   ) u_divider (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .in_valid  (s4_valid_ff),
      .in_num    (mag_ff),
      .in_den    (den_ff),
      .in_tag    (tag4_ff),
      .out_valid (div_valid),
      .out_quo   (div_quo),
      .out_tag   (div_tag)
   );

   // saturation stage: clamp to 34 bits signed, apply the sign, zero on a zero divisor
   logic                   s5_valid_ff;
   logic [FLIGHT_BITS-1:0] flight5_ff;
   logic                   zero5_ff;
   logic [EXT-1:0]         quo_ext;
   logic [EXT-1:0]         quo_sat;
   logic [FLIGHT_BITS-1:0] flight5_in;

   assign quo_ext = EXT'(div_quo);

   always_comb begin
      if (div_tag.neg) begin
         quo_sat = (quo_ext > NEG_LIMIT) ? NEG_LIMIT : quo_ext;
      end else begin
         quo_sat = (quo_ext > POS_LIMIT) ? POS_LIMIT : quo_ext;
      end
      if (div_tag.zero) begin
         flight5_in = '0;
      end else if (div_tag.neg) begin
         flight5_in = '0 - quo_sat[FLIGHT_BITS-1:0];
      end else begin
         flight5_in = quo_sat[FLIGHT_BITS-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s5_valid_ff <= 1'b0;
      end else if (advance) begin
         s5_valid_ff <= div_valid;
         flight5_ff  <= flight5_in;
         zero5_ff    <= div_tag.zero;
      end
   end

   // output register with skid register behind it
   logic                   out_valid_ff;
   logic [FLIGHT_BITS-1:0] out_flight_ff;
   logic                   out_zero_ff;
   logic [FLIGHT_BITS-1:0] skid_flight_ff;
   logic                   skid_zero_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (skid_valid_ff) begin
         // pipeline is halted; drain the skid once the output is taken
         if (rsp_ready) begin
            out_flight_ff <= skid_flight_ff;
            out_zero_ff   <= skid_zero_ff;
            skid_valid_ff <= 1'b0;
         end
      end else if (s5_valid_ff) begin
         if (!out_valid_ff || rsp_ready) begin
            out_valid_ff  <= 1'b1;
            out_flight_ff <= flight5_ff;
            out_zero_ff   <= zero5_ff;
         end else begin
            skid_valid_ff  <= 1'b1;
            skid_flight_ff <= flight5_ff;
            skid_zero_ff   <= zero5_ff;
         end
      end else if (rsp_ready) begin
         out_valid_ff <= 1'b0;
      end
   end

   assign rsp_valid        = out_valid_ff;
   assign rsp_flight_time  = signed'(out_flight_ff);
   assign rsp_zero_divisor = out_zero_ff;

endmodule

`default_nettype wire

>>> dv/ds_twr_time_of_flight_tb.sv
// self-checking testbench for the two-way ranging time-of-flight block
`default_nettype none

module ds_twr_time_of_flight_tb
   import dstwr_pkg::*;
;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int STAMP_BITS = DEF_STAMP_BITS;
   // request transfer to rsp_valid, counted over the block's registered stages
   localparam int LATENCY    = 2 * STAMP_BITS + 6;

   typedef logic [STAMP_BITS-1:0] stamp_type;
   typedef logic [127:0]          wide_type;

   // the six timestamps of one ranging exchange, as carried by one request
   typedef struct packed {
      stamp_type remote_poll_sent;
      stamp_type remote_reply_seen;
      stamp_type remote_final_sent;
      stamp_type local_poll_seen;
      stamp_type local_reply_sent;
      stamp_type local_final_seen;
   } exchange_type;

   typedef struct {
      logic signed [FLIGHT_BITS-1:0] flight_time;
      logic                          zero_divisor;
   } flight_result_type;

   // saturation bounds of the 34-bit signed result
   localparam wide_type POS_FLIGHT_MAX = (wide_type'(1) << (FLIGHT_BITS - 1)) - 1;
   localparam wide_type NEG_FLIGHT_MAG = wide_type'(1) << (FLIGHT_BITS - 1);

   logic      clock = 1'b0;
   logic      reset = 1'b1;
   logic      req_valid = 1'b0;
   logic      req_ready;
   stamp_type req_remote_poll_sent  = '0;
   stamp_type req_remote_reply_seen = '0;
   stamp_type req_remote_final_sent = '0;
   stamp_type req_local_poll_seen   = '0;
   stamp_type req_local_reply_sent  = '0;
   stamp_type req_local_final_seen  = '0;
   logic      rsp_valid;
   logic      rsp_ready = 1'b0;
   logic signed [FLIGHT_BITS-1:0] rsp_flight_time;
   logic      rsp_zero_divisor;

   // flight times still owed by the block, oldest first
   flight_result_type expected_flights[$];

   int send_idle_pct   = 0;
   int recv_idle_pct   = 0;
   int rsp_hold_cycles = 0;   // long receiver hold-off, counted down below
   int mismatch_count  = 0;
   int results_seen    = 0;

   ds_twr_time_of_flight #(
      .STAMP_BITS (STAMP_BITS)
   ) dut (
      .clock                 (clock),
      .reset                 (reset),
      .req_valid             (req_valid),
      .req_ready             (req_ready),
      .req_remote_poll_sent  (req_remote_poll_sent),
      .req_remote_reply_seen (req_remote_reply_seen),
      .req_remote_final_sent (req_remote_final_sent),
      .req_local_poll_seen   (req_local_poll_seen),
      .req_local_reply_sent  (req_local_reply_sent),
      .req_local_final_seen  (req_local_final_seen),
      .rsp_valid             (rsp_valid),
      .rsp_ready             (rsp_ready),
      .rsp_flight_time       (rsp_flight_time),
      .rsp_zero_divisor      (rsp_zero_divisor)
   );

   // 8 ns period
   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // exact integer time of flight: (Ra*Rb - Da*Db) / (Ra+Rb+Da+Db),
   // truncated toward zero, saturated to 34 bits signed
   function automatic flight_result_type predict_flight(input exchange_type x);
      stamp_type         ra, rb, da, db;
      wide_type          wra, wrb, wda, wdb;
      wide_type          sum, round_prod, reply_prod, num, mag, neg_mag;
      logic              neg;
      flight_result_type r;
      // intervals wrap modulo 2^STAMP_BITS like the hardware counters
      ra  = x.remote_reply_seen - x.remote_poll_sent;
      rb  = x.local_final_seen  - x.local_reply_sent;
      da  = x.remote_final_sent - x.remote_reply_seen;
      db  = x.local_reply_sent  - x.local_poll_seen;
      wra = ra;
      wrb = rb;
      wda = da;
      wdb = db;
      sum = wra + wrb + wda + wdb;
      r.flight_time  = '0;
      r.zero_divisor = 1'b0;
      if (sum == 0) begin
         // every interval is zero: flag it and give zero
         r.zero_divisor = 1'b1;
         return r;
      end
      round_prod = wra * wrb;
      reply_prod = wda * wdb;
      neg = reply_prod > round_prod;
      num = neg ? reply_prod - round_prod : round_prod - reply_prod;
      // dividing the magnitude truncates toward zero for either sign
      mag = num / sum;
      if (neg) begin
         if (mag > NEG_FLIGHT_MAG) begin
            mag = NEG_FLIGHT_MAG;
         end
         neg_mag = -mag;
         r.flight_time = neg_mag[FLIGHT_BITS-1:0];
      end else begin
         if (mag > POS_FLIGHT_MAX) begin
            mag = POS_FLIGHT_MAX;
         end
         r.flight_time = mag[FLIGHT_BITS-1:0];
      end
      return r;
   endfunction

   // lay out an exchange from its four intervals and the two device clocks
   function automatic exchange_type make_exchange(input stamp_type ra, input stamp_type rb,
                                                  input stamp_type da, input stamp_type db,
                                                  input stamp_type t0, input stamp_type l0);
      exchange_type x;
      x.remote_poll_sent  = t0;
      x.remote_reply_seen = t0 + ra;
      x.remote_final_sent = t0 + ra + da;
      x.local_poll_seen   = l0;
      x.local_reply_sent  = l0 + db;
      x.local_final_seen  = l0 + db + rb;
      return x;
   endfunction

   // random interval with a random magnitude, from a few ticks to full range
   function automatic stamp_type rand_interval();
      stamp_type v;
      v = stamp_type'($urandom);
      return v >> $urandom_range(STAMP_BITS - 1, 0);
   endfunction

   task automatic report_mismatch(input string what, input longint want,
                                  input longint got);
      $display("result %0d: %s: expected %0d, got %0d",
               results_seen, what, want, got);
      mismatch_count++;
   endtask

   // one request transfer; valid is only lowered across an idle gap, so a
   // back-to-back transfer never lowers and raises it in the same step
   task automatic send_exchange(input exchange_type x);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid             <= 1'b1;
      req_remote_poll_sent  <= x.remote_poll_sent;
      req_remote_reply_seen <= x.remote_reply_seen;
      req_remote_final_sent <= x.remote_final_sent;
      req_local_poll_seen   <= x.local_poll_seen;
      req_local_reply_sent  <= x.local_reply_sent;
      req_local_final_seen  <= x.local_final_seen;
      @(posedge clock);
      while (!req_ready) begin
         @(posedge clock);
      end
      expected_flights.push_back(predict_flight(x));
   endtask

   // stop offering and let every owed result come back
   task automatic wait_for_drain();
      req_valid <= 1'b0;
      while (expected_flights.size() != 0) begin
         @(posedge clock);
      end
   endtask

   // receiver: random stalls, or a long hold-off when one is asked for
   always @(posedge clock) begin
      if (rsp_hold_cycles > 0) begin
         rsp_ready <= 1'b0;
         rsp_hold_cycles = rsp_hold_cycles - 1;
      end else begin
         rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   // compare each result transfer with the oldest owed flight time
   always @(posedge clock) begin : check_results
      flight_result_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_flights.size() == 0) begin
            report_mismatch("transfer with nothing owed", 0, rsp_flight_time);
         end else begin
            want = expected_flights.pop_front();
            if (rsp_flight_time !== want.flight_time) begin
               report_mismatch("flight_time", want.flight_time, rsp_flight_time);
            end
            if (rsp_zero_divisor !== want.zero_divisor) begin
               report_mismatch("zero_divisor", want.zero_divisor, rsp_zero_divisor);
            end
         end
         results_seen++;
      end
   end

   // all intervals zero, whatever the clock bases
   task automatic test_zero_divisor();
      send_exchange(make_exchange('0, '0, '0, '0, '0, '0));
      send_exchange(make_exchange('0, '0, '0, '0, '1, '1));
      send_exchange(make_exchange('0, '0, '0, '0, stamp_type'($urandom),
                                  stamp_type'($urandom)));
   endtask

   // widest intervals, counter wrap and bit patterns
   task automatic test_extremes();
      exchange_type x;
      // largest positive and negative flight times, then two that come to zero
      send_exchange(make_exchange('1, '1, '0, '0, '0, '0));
      send_exchange(make_exchange('0, '0, '1, '1, '0, '0));
      send_exchange(make_exchange('1, '1, '1, '1, '1, '0));
      send_exchange(make_exchange('1, 1, '0, '0, '0, '0));
      // intervals that straddle the counter wrap
      send_exchange(make_exchange(32'h100, 32'h2000, 32'h300, 32'h1F00,
                                  32'hFFFF_FFF0, 32'hFFFF_FF00));
      // each stamp earlier than its partner: huge wrapped intervals
      x = '{remote_poll_sent: 100, remote_reply_seen: 50, remote_final_sent: 10,
            local_poll_seen: 900, local_reply_sent: 800, local_final_seen: 700};
      send_exchange(x);
      x = '{remote_poll_sent: 32'h5555_5555, remote_reply_seen: 32'hAAAA_AAAA,
            remote_final_sent: 32'h5555_5555, local_poll_seen: 32'hAAAA_AAAA,
            local_reply_sent: 32'h5555_5555, local_final_seen: 32'hAAAA_AAAA};
      send_exchange(x);
      x = '{remote_poll_sent: 32'hAAAA_AAAA, remote_reply_seen: 32'h5555_5555,
            remote_final_sent: 32'hFFFF_FFFF, local_poll_seen: 32'h0000_0000,
            local_reply_sent: 32'hFFFF_FFFF, local_final_seen: 32'h5555_5555};
      send_exchange(x);
      // a plain exchange: flight 500, reply delays 10000 and 12000
      send_exchange(make_exchange(11000, 13000, 12000, 10000, 32'h1234_5678,
                                  32'h9ABC_DEF0));
   endtask

   // sign of the result and truncation toward zero on both sides
   task automatic test_sign_and_truncation();
      send_exchange(make_exchange(0, 0, 1, 2, 7, 9));   // -2/3 gives 0
      send_exchange(make_exchange(0, 0, 2, 2, 7, 9));   // -4/4 gives -1
      send_exchange(make_exchange(0, 0, 3, 4, 7, 9));   // -12/7 gives -1
      send_exchange(make_exchange(3, 4, 0, 0, 7, 9));   // 12/7 gives 1
      send_exchange(make_exchange(1, 1, 0, 0, 7, 9));   // 1/2 gives 0
      send_exchange(make_exchange(5, 5, 1, 1, 7, 9));   // 24/12 gives 2
      send_exchange(make_exchange(0, 0, 0, 1, 7, 9));   // single nonzero interval
      send_exchange(make_exchange(6, 6, 6, 6, 7, 9));   // products cancel
   endtask

   // mostly well-formed exchanges around a true flight time, plus noise
   task automatic test_random_exchanges(input int count);
      stamp_type tof, ra, rb, da, db;
      int        kind;
      for (int n = 0; n < count; n++) begin
         kind = $urandom_range(99);
         if (kind < 70) begin
            tof = $urandom_range(3000);
            da  = rand_interval();
            db  = rand_interval();
            // slight clock drift between the two devices
            ra  = 2 * tof + db + $urandom_range(3);
            rb  = 2 * tof + da + $urandom_range(3);
         end else if (kind < 90) begin
            send_exchange(exchange_type'({$urandom, $urandom, $urandom,
                                          $urandom, $urandom, $urandom}));
            continue;
         end else begin
            // intervals picked among zero, all ones and random sizes
            ra = ($urandom_range(2) == 0) ? '0 : ($urandom_range(1) ? '1 : rand_interval());
            rb = ($urandom_range(2) == 0) ? '0 : ($urandom_range(1) ? '1 : rand_interval());
            da = ($urandom_range(2) == 0) ? '0 : ($urandom_range(1) ? '1 : rand_interval());
            db = ($urandom_range(2) == 0) ? '0 : ($urandom_range(1) ? '1 : rand_interval());
         end
         send_exchange(make_exchange(ra, rb, da, db, stamp_type'($urandom),
                                     stamp_type'($urandom)));
      end
   endtask

   // long receiver hold-off with back-to-back requests: the pipeline and
   // skid register fill and req_ready must drop without losing a transfer
   task automatic test_backpressure();
      int saved_pct;
      saved_pct = send_idle_pct;
      send_idle_pct = 0;
      rsp_hold_cycles = 4 * LATENCY + 100;
      test_random_exchanges(LATENCY + 40);
      send_idle_pct = saved_pct;
   endtask

   // sender pauses until the pipeline is empty, then carries on
   task automatic test_drain_pause();
      test_random_exchanges(10);
      wait_for_drain();
      test_random_exchanges(10);
   endtask

   initial begin
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // sender idles lightly, receiver stalls often
      send_idle_pct = 14;
      recv_idle_pct = 61;
      test_zero_divisor();
      test_extremes();
      test_sign_and_truncation();
      test_random_exchanges(390);

      // the other way round
      send_idle_pct = 61;
      recv_idle_pct = 14;
      test_random_exchanges(390);
      test_drain_pause();
      test_backpressure();

      // neither side idles
      send_idle_pct = 0;
      recv_idle_pct = 0;
      test_random_exchanges(380);

      wait_for_drain();
      // room for any stray transfer to show up
      repeat (LATENCY + 20) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

   // run limit, far above the slowest correct run
   initial begin
      #4_000_000;
      $display("Mismatches found");
      $finish;
   end

endmodule

`default_nettype wire
